// File: rtl/core/cbez_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier sampler.
// No dependencies.
package cbez_pkg;

	localparam int IDX_W = 11;
	localparam int NUM_PTS = 4;
	localparam int NUM_AXES = 2;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             clamped;
		logic             sat;
	} tag_t;

endpackage

// File: rtl/core/cbez_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: produces one quotient bit per cycle.
// Depends on cbez_pkg.
module cbez_div_cell #(
	parameter int FRACTION_BITS = 16,
	parameter int PTS_W = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vld_in,
	input  cbez_pkg::tag_t                  tag_in,
	input  logic [PTS_W-1:0]                pts_in,
	input  logic [cbez_pkg::IDX_W-1:0]      seg_in,
	input  logic [cbez_pkg::IDX_W-1:0]      rem_in,
	input  logic [FRACTION_BITS-1:0]        quo_in,
	output logic                            vld_out,
	output cbez_pkg::tag_t                  tag_out,
	output logic [PTS_W-1:0]                pts_out,
	output logic [cbez_pkg::IDX_W-1:0]      seg_out,
	output logic [cbez_pkg::IDX_W-1:0]      rem_out,
	output logic [FRACTION_BITS-1:0]        quo_out
);
	logic [cbez_pkg::IDX_W:0] rem2;
	logic                     ge;
	logic [cbez_pkg::IDX_W:0] diff;

	assign rem2 = {rem_in, 1'b0};
	assign ge   = rem2 >= {1'b0, seg_in};
	assign diff = rem2 - {1'b0, seg_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		tag_out <= tag_in;
		pts_out <= pts_in;
		seg_out <= seg_in;
		rem_out <= ge ? diff[cbez_pkg::IDX_W-1:0] : rem2[cbez_pkg::IDX_W-1:0];
		quo_out <= {quo_in[FRACTION_BITS-2:0], ge};
	end
endmodule

// File: rtl/core/cbez_lerp_cell.sv
`timescale 1ns / 1ps
// One de Casteljau cell: a*s + b*t, exact; the products are registered, then their sum.
// Depends on nothing.
module cbez_lerp_cell #(
	parameter int W = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic signed [W-1:0]           a,
	input  logic signed [W-1:0]           b,
	input  logic [FRACTION_BITS:0]        s,
	input  logic [FRACTION_BITS:0]        t,
	output logic signed [W+FRACTION_BITS-1:0] y
);
	localparam int PW = W + FRACTION_BITS + 2;

	logic signed [PW-1:0] pa_s1;
	logic signed [PW-1:0] pb_s1;
	logic signed [PW-1:0] sum;

	assign sum = pa_s1 + pb_s1;

	always_ff @(posedge clk) begin
		pa_s1 <= a * $signed({1'b0, s});
		pb_s1 <= b * $signed({1'b0, t});
		y     <= sum[W+FRACTION_BITS-1:0];
	end
endmodule

// File: rtl/core/cubic_bezier_sampler_unit.sv
`timescale 1ns / 1ps
// Cubic Bezier sampler: one beat per clock.
// t comes from a row of FRACTION_BITS division cells, one quotient bit per cell; then
// three de Casteljau levels, each a multiply register and an add register, and a rounding register.
// busy is never raised; done strobes each result for one cycle.
// Reset clears the valid bits only.
module cubic_bezier_sampler_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COORD_BITS-1:0]     first_x,
	input  logic signed [COORD_BITS-1:0]     first_y,
	input  logic signed [COORD_BITS-1:0]     second_x,
	input  logic signed [COORD_BITS-1:0]     second_y,
	input  logic signed [COORD_BITS-1:0]     third_x,
	input  logic signed [COORD_BITS-1:0]     third_y,
	input  logic signed [COORD_BITS-1:0]     fourth_x,
	input  logic signed [COORD_BITS-1:0]     fourth_y,
	input  logic [cbez_pkg::IDX_W-1:0]       segments,
	input  logic [cbez_pkg::IDX_W-1:0]       sample_index,
	output logic                             done,
	output logic signed [COORD_BITS-1:0]     point_x,
	output logic signed [COORD_BITS-1:0]     point_y,
	output logic [cbez_pkg::IDX_W-1:0]       point_index,
	output logic                             last_point,
	output logic                             index_clamped
);
	localparam int C = COORD_BITS;
	localparam int F = FRACTION_BITS;
	localparam int IW = cbez_pkg::IDX_W;
	localparam int PTS_W = 8 * C;
	localparam int W3 = C + 3 * F;
	localparam int LAT = F + 9;

	assign busy = 1'b0;

	// input beat
	logic             vld_s1;
	cbez_pkg::tag_t   tag_s1;
	logic [PTS_W-1:0] pts_s1;
	logic [IW-1:0]    seg_s1;
	logic [IW-1:0]    rem_s1;
	logic             sat;

	assign sat = (segments == '0) || (sample_index >= segments);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.idx     <= sample_index;
		tag_s1.last    <= sample_index == segments;
		tag_s1.clamped <= sample_index > segments;
		tag_s1.sat     <= sat;
		pts_s1 <= {fourth_y, fourth_x, third_y, third_x, second_y, second_x, first_y, first_x};
		seg_s1 <= segments;
		rem_s1 <= sat ? '0 : sample_index;
	end

	// division chain
	logic             dv_vld [0:F];
	cbez_pkg::tag_t   dv_tag [0:F];
	logic [PTS_W-1:0] dv_pts [0:F];
	logic [IW-1:0]    dv_seg [0:F];
	logic [IW-1:0]    dv_rem [0:F];
	logic [F-1:0]     dv_quo [0:F];

	assign dv_vld[0] = vld_s1;
	assign dv_tag[0] = tag_s1;
	assign dv_pts[0] = pts_s1;
	assign dv_seg[0] = seg_s1;
	assign dv_rem[0] = rem_s1;
	assign dv_quo[0] = '0;

	for (genvar i = 0; i < F; i++) begin : g_div
		cbez_div_cell #(.FRACTION_BITS(F), .PTS_W(PTS_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (dv_vld[i]),
			.tag_in  (dv_tag[i]),
			.pts_in  (dv_pts[i]),
			.seg_in  (dv_seg[i]),
			.rem_in  (dv_rem[i]),
			.quo_in  (dv_quo[i]),
			.vld_out (dv_vld[i+1]),
			.tag_out (dv_tag[i+1]),
			.pts_out (dv_pts[i+1]),
			.seg_out (dv_seg[i+1]),
			.rem_out (dv_rem[i+1]),
			.quo_out (dv_quo[i+1])
		);
	end

	// t / s and tag delay line through the lerp levels
	logic           vld_q [0:6];
	cbez_pkg::tag_t tag_q [0:6];
	logic [F:0]     t_q   [0:4];
	logic [F:0]     s_q   [0:4];
	logic [F:0]     t_in;

	assign t_in = dv_tag[F].sat ? {1'b1, {F{1'b0}}} : {1'b0, dv_quo[F]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 7; k++) vld_q[k] <= 1'b0;
		end else begin
			vld_q[0] <= dv_vld[F];
			for (int k = 1; k < 7; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= dv_tag[F];
		t_q[0]   <= t_in;
		s_q[0]   <= {1'b1, {F{1'b0}}} - t_in;
		for (int k = 1; k < 7; k++) tag_q[k] <= tag_q[k-1];
		for (int k = 1; k < 5; k++) begin
			t_q[k] <= t_q[k-1];
			s_q[k] <= s_q[k-1];
		end
	end

	logic signed [C-1:0]     l0_q [0:1][0:3];
	logic signed [C+F-1:0]   l1   [0:1][0:2];
	logic signed [C+2*F-1:0] l2   [0:1][0:1];
	logic signed [W3-1:0]    l3   [0:1];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++)
			for (int p = 0; p < 4; p++)
				l0_q[a][p] <= dv_pts[F][(2*p+a)*C +: C];
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		for (genvar p = 0; p < 3; p++) begin : g_l1
			cbez_lerp_cell #(.W(C), .FRACTION_BITS(F)) u_cell (
				.clk (clk), .a (l0_q[a][p]), .b (l0_q[a][p+1]),
				.s (s_q[0]), .t (t_q[0]), .y (l1[a][p])
			);
		end
		for (genvar p = 0; p < 2; p++) begin : g_l2
			cbez_lerp_cell #(.W(C+F), .FRACTION_BITS(F)) u_cell (
				.clk (clk), .a (l1[a][p]), .b (l1[a][p+1]),
				.s (s_q[2]), .t (t_q[2]), .y (l2[a][p])
			);
		end
		cbez_lerp_cell #(.W(C+2*F), .FRACTION_BITS(F)) u_l3 (
			.clk (clk), .a (l2[a][0]), .b (l2[a][1]),
			.s (s_q[4]), .t (t_q[4]), .y (l3[a])
		);
	end

	// round half up and emit
	logic [W3-1:0] rx;
	logic [W3-1:0] ry;

	assign rx = l3[0] + {{(W3-3*F){1'b0}}, 1'b1, {(3*F-1){1'b0}}};
	assign ry = l3[1] + {{(W3-3*F){1'b0}}, 1'b1, {(3*F-1){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[6];
		end
	end

	always_ff @(posedge clk) begin
		point_x       <= rx[3*F +: C];
		point_y       <= ry[3*F +: C];
		point_index   <= tag_q[6].idx;
		last_point    <= tag_q[6].last;
		index_clamped <= tag_q[6].clamped;
	end

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(last_point && index_clamped))
		else $error("last and clamped both set");
	a_end_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (last_point || index_clamped)) |->
			(point_x == $past(fourth_x, LAT) && point_y == $past(fourth_y, LAT)))
		else $error("t=1 result differs from end point");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching start");
	a_index_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> point_index == $past(sample_index, LAT))
		else $error("index echo mismatch");
endmodule

// File: tb/cubic_bezier_sampler_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for cubic_bezier_sampler_unit: directed and random samples, checked against
// a bit-exact Bernstein-sum predictor. Depends on cbez_pkg and the sampler RTL.
module cubic_bezier_sampler_unit_tb;

	localparam int CW = 16;
	localparam int FB = 16;
	localparam int IW = cbez_pkg::IDX_W;
	localparam int SETTLE = 40;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic signed [CW-1:0] px [4];
		logic signed [CW-1:0] py [4];
		logic [IW-1:0] seg;
		logic [IW-1:0] idx;
		int gap;
	} sample_req_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [IW-1:0] idx;
		logic last;
		logic clamped;
	} curve_pt_t;

	logic clk = 0, arst_n = 0, start = 0, busy, done;
	logic signed [CW-1:0] first_x = 0, first_y = 0, second_x = 0, second_y = 0;
	logic signed [CW-1:0] third_x = 0, third_y = 0, fourth_x = 0, fourth_y = 0;
	logic [IW-1:0] segments = 0, sample_index = 0;
	logic signed [CW-1:0] point_x, point_y;
	logic [IW-1:0] point_index;
	logic last_point, index_clamped;

	sample_req_t pending_q [$];
	curve_pt_t points_due [$];
	int mismatches = 0, wait_cnt = 0, stall_cycles = 0;

	cubic_bezier_sampler_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [CW-1:0] bernstein_axis(logic signed [CW-1:0] p0,
			logic signed [CW-1:0] p1, logic signed [CW-1:0] p2,
			logic signed [CW-1:0] p3, logic [FB:0] t, logic [FB:0] s);
		logic signed [127:0] a0, a1, a2, a3, tw, sw, acc;
		a0 = {{(128-CW){p0[CW-1]}}, p0};
		a1 = {{(128-CW){p1[CW-1]}}, p1};
		a2 = {{(128-CW){p2[CW-1]}}, p2};
		a3 = {{(128-CW){p3[CW-1]}}, p3};
		tw = {{(127-FB){1'b0}}, t};
		sw = {{(127-FB){1'b0}}, s};
		acc = a0 * sw * sw * sw + 128'sd3 * a1 * tw * sw * sw
			+ 128'sd3 * a2 * tw * tw * sw + a3 * tw * tw * tw;
		acc = (acc + (128'sd1 <<< (3 * FB - 1))) >>> (3 * FB);
		return acc[CW-1:0];
	endfunction

	function automatic curve_pt_t sample_curve(sample_req_t r);
		curve_pt_t p;
		logic [FB:0] t, s;
		logic [63:0] q;
		if (r.seg == 0 || r.idx >= r.seg) begin
			t = {1'b1, {FB{1'b0}}};
		end else begin
			q = ({{(64-IW){1'b0}}, r.idx} << FB) / r.seg;
			t = q[FB:0];
		end
		s = {1'b1, {FB{1'b0}}} - t;
		p.x = bernstein_axis(r.px[0], r.px[1], r.px[2], r.px[3], t, s);
		p.y = bernstein_axis(r.py[0], r.py[1], r.py[2], r.py[3], t, s);
		p.idx = r.idx;
		p.last = r.idx == r.seg;
		p.clamped = r.idx > r.seg;
		return p;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		sample_req_t r, cur;
		if (!arst_n) begin
			start <= 0;
		end else begin
			if (start && !busy) begin
				cur.px = '{first_x, second_x, third_x, fourth_x};
				cur.py = '{first_y, second_y, third_y, fourth_y};
				cur.seg = segments;
				cur.idx = sample_index;
				points_due.push_back(sample_curve(cur));
			end
			if (!start || !busy) begin
				if (wait_cnt > 0) begin
					wait_cnt <= wait_cnt - 1;
					start <= 0;
				end else if (pending_q.size() > 0) begin
					r = pending_q.pop_front();
					first_x <= r.px[0]; second_x <= r.px[1];
					third_x <= r.px[2]; fourth_x <= r.px[3];
					first_y <= r.py[0]; second_y <= r.py[1];
					third_y <= r.py[2]; fourth_y <= r.py[3];
					segments <= r.seg;
					sample_index <= r.idx;
					wait_cnt <= r.gap;
					start <= 1;
				end else begin
					start <= 0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		curve_pt_t e;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("cubic_bezier_sampler_unit_tb failed");
				$finish;
			end
		end
		if (done) begin
			if (points_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: x=%0d y=%0d idx=%0d", point_x, point_y,
						point_index);
			end else begin
				e = points_due.pop_front();
				if (e.x !== point_x || e.y !== point_y || e.idx !== point_index
						|| e.last !== last_point || e.clamped !== index_clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
							e.x, e.y, e.idx, e.last, e.clamped, point_x, point_y,
							point_index, last_point, index_clamped);
				end
			end
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return v[CW-1:0];
		endcase
	endfunction

	task automatic add_sample(int seg, int idx, int gap, int fill, bit rnd);
		sample_req_t r;
		for (int k = 0; k < 4; k++) begin
			r.px[k] = rnd ? rand_coord() : fill[CW-1:0];
			r.py[k] = rnd ? rand_coord() : fill[CW-1:0];
		end
		r.seg = seg[IW-1:0];
		r.idx = idx[IW-1:0];
		r.gap = gap;
		pending_q.push_back(r);
	endtask

	initial begin
		int burst, seg, idx, gap;
		add_sample(4, 2, 0, 16'sh8000, 1'b0);
		add_sample(4, 2, 1, 16'sh7FFF, 1'b0);
		add_sample(1, 0, 0, 16'sh8000, 1'b0);
		add_sample(1, 1, 0, 16'sh7FFF, 1'b0);
		add_sample(1, 2, 2, 0, 1'b1);
		add_sample(0, 0, 0, 0, 1'b1);
		add_sample(0, 5, 0, 0, 1'b1);
		add_sample(0, 2047, 3, 0, 1'b1);
		add_sample(1024, 1024, 0, 0, 1'b1);
		add_sample(1024, 1023, 0, 0, 1'b1);
		add_sample(1024, 1, 0, 0, 1'b1);
		add_sample(2047, 2047, 0, 0, 1'b1);
		add_sample(2047, 2046, 1, 0, 1'b1);
		add_sample(3, 1, 0, 0, 1'b1);
		add_sample(3, 2, 0, 0, 1'b1);
		add_sample(5, 1000, 0, 0, 1'b1);
		add_sample(7, 3, 14, 0, 1'b1);
		add_sample(2, 1, 0, 16'sh7FFF, 1'b0);
		burst = 0;
		for (int n = 0; n < 700; n++) begin
			if (n % 50 == 0)
				burst = $urandom_range(0, 2) == 0;
			case ($urandom_range(0, 9))
				0: begin
					seg = $urandom_range(0, 2047);
					idx = $urandom_range(0, 2047);
				end
				1: begin
					seg = $urandom_range(1, 1024);
					idx = $urandom_range(0, 1) ? seg : 0;
				end
				default: begin
					seg = $urandom_range(1, 1024);
					idx = $urandom_range(0, seg);
				end
			endcase
			gap = burst ? 0 : $urandom_range(0, 14);
			add_sample(seg, idx, gap, 0, 1'b1);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1;
		wait (pending_q.size() == 0 && !start && wait_cnt == 0 && points_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && points_due.size() == 0)
			$display("cubic_bezier_sampler_unit_tb passed");
		else
			$display("cubic_bezier_sampler_unit_tb failed");
		$finish;
	end
endmodule
